@@ rtl/sphc_pkg.sv @@
// ----------------------------------------------------------------------------
// sphc_pkg
// Shared constants and types for the sphere carve vertex remap block.
// ----------------------------------------------------------------------------
package sphc_pkg;

    localparam int REG_W  = 24;
    localparam int RAD_W  = 23;
    localparam int IDX_W  = 12;
    localparam int D2_W   = 48;
    localparam int ROOT_W = 32;
    localparam int NUM_W  = 55;
    localparam int SUM_W  = 57;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_CENTER_X = 2'd0;
    localparam cfg_idx_t CFG_CENTER_Y = 2'd1;
    localparam cfg_idx_t CFG_CENTER_Z = 2'd2;
    localparam cfg_idx_t CFG_RADIUS   = 2'd3;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd8192;

endpackage

@@ rtl/sphere_carve_vertex_remap.sv @@
// ----------------------------------------------------------------------------
// sphere_carve_vertex_remap
// Index de-duplication with sphere carving of newly emitted vertices.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one old index with its vertex per
// transaction; output channel (out_valid/out_ready) returns one result per
// input. Config channel (cfg_valid/cfg_ready, always ready) writes the sphere
// center and radius; write only while the block is idle.
// One item is processed at a time; the next transaction can be accepted once
// out_valid has risen. A repeated index passes S_MAP and S_REV to S_OUT; a new
// vertex outside the bounding box of the sphere also passes S_DIFF. One inside
// the box sums the squared axis distances and compares them with the squared
// radius; one not strictly inside the sphere, or at the center, then goes to
// S_OUT. One that is projected runs the 2-bit-per-cycle square root, then the
// bit-serial divider shared by the axes for each axis in turn.
// The map lives in two synchronous RAMs (old->new and new->old); an entry
// counts as seen when both agree below the fill count, so start_mesh clears
// the map by resetting the fill count. After reset a clearing pass zeroes
// every entry of the old->new RAM; in_ready stays low until it ends.
// The next input is accepted while a finished result waits in the output
// register; a stalled receiver holds the block in its final state.
// Reset clears control state, fill count and center; radius resets to 8192.
// ----------------------------------------------------------------------------
module sphere_carve_vertex_remap #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [sphc_pkg::REG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             start_mesh,
    input  logic [sphc_pkg::IDX_W-1:0]       old_index,
    input  logic signed [COORD_WIDTH-1:0]    pos_x,
    input  logic signed [COORD_WIDTH-1:0]    pos_y,
    input  logic signed [COORD_WIDTH-1:0]    pos_z,
    input  logic signed [COORD_WIDTH-1:0]    attr_a,
    input  logic signed [COORD_WIDTH-1:0]    attr_b,
    input  logic signed [COORD_WIDTH-1:0]    attr_c,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sphc_pkg::IDX_W-1:0]       new_index,
    output logic                             emits_vertex,
    output logic signed [COORD_WIDTH-1:0]    out_x,
    output logic signed [COORD_WIDTH-1:0]    out_y,
    output logic signed [COORD_WIDTH-1:0]    out_z,
    output logic signed [COORD_WIDTH-1:0]    out_attr_a,
    output logic signed [COORD_WIDTH-1:0]    out_attr_b,
    output logic signed [COORD_WIDTH-1:0]    out_attr_c,
    output logic                             carved
);

    localparam int SW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = SW + 1;
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = ((CW > sphc_pkg::REG_W) ? CW : sphc_pkg::REG_W) + 1;
    localparam int RW    = sphc_pkg::RAD_W;
    localparam int IW    = sphc_pkg::IDX_W;
    localparam int NW    = sphc_pkg::NUM_W;
    localparam int QW    = sphc_pkg::ROOT_W;
    localparam int SUMW  = sphc_pkg::SUM_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
    localparam logic signed [SUMW-1:0] SAT_HI = (SUMW'(1) <<< (CW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MAP, S_REV, S_DIFF, S_SQ, S_RCMP, S_SQRT, S_MUL, S_DIV, S_AXIS,
        S_OUT
    } state_t;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[CW-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    state_t                      state_reg;
    logic [SW-1:0]               clr_reg;
    logic signed [sphc_pkg::REG_W-1:0] cen_reg [3];
    logic [RW-1:0]               rad_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [SW-1:0]               slot_reg;
    logic signed [CW-1:0]        pos_reg [3];
    logic signed [CW-1:0]        attr_reg [3];
    logic [RW-1:0]               ad_reg [3];
    logic [2:0]                  neg_reg;
    logic [1:0]                  ax_reg;
    logic [sphc_pkg::D2_W-1:0]   acc_reg;
    logic [63:0]                 sq_n_reg;
    logic [QW+1:0]               sq_rem_reg;
    logic [QW-1:0]               root_reg;
    logic [5:0]                  it_reg;
    logic [NW-1:0]               div_n_reg;
    logic [QW-1:0]               div_rem_reg;
    logic [SW-1:0]               ni_reg;
    logic                        emit_reg;
    logic                        carved_reg;
    logic signed [CW-1:0]        res_reg [3];

    logic                        out_valid_reg;
    logic [IW-1:0]               new_index_reg;
    logic                        emits_vertex_reg;
    logic                        carved_out_reg;
    logic signed [CW-1:0]        out_pos_reg [3];
    logic signed [CW-1:0]        out_attr_reg [3];

    logic [SW-1:0]               map_mem [MAX_VERTICES];
    logic [SW-1:0]               rev_mem [MAX_VERTICES];
    logic [SW-1:0]               map_q;
    logic [SW-1:0]               rev_q;

    logic                        in_acc;
    logic [SW-1:0]               in_slot;
    logic                        seen;
    logic                        map_we;
    logic signed [DW-1:0]        d [3];
    logic [DW-1:0]               ad [3];
    logic [2:0]                  box;
    logic [2*RW-1:0]             sq_prod;
    logic [2*RW-1:0]             rr;
    logic [2*RW-1:0]             ax_prod;
    logic [QW+1:0]               sq_trial;
    logic [QW+1:0]               sq_shift;
    logic [QW:0]                 div_shift;
    logic [SUMW-1:0]             q_ext;
    logic signed [SUMW-1:0]      axis_sum;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign in_slot   = SW'({{SW{1'b0}}, old_index});
    assign seen      = ({1'b0, map_q} < cnt_reg) && (rev_q == slot_reg);
    assign map_we    = (state_reg == S_REV) && !seen;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i]   = DW'(pos_reg[i]) - DW'(cen_reg[i]);
            ad[i]  = d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
            box[i] = ad[i] < DW'(rad_reg);
        end
    end

    assign sq_prod   = ad_reg[ax_reg] * ad_reg[ax_reg];
    assign rr        = rad_reg * rad_reg;
    assign ax_prod   = ad_reg[ax_reg] * rad_reg;
    assign sq_shift  = {sq_rem_reg[QW-1:0], sq_n_reg[63:62]};
    assign sq_trial  = {root_reg, 2'b01};
    assign div_shift = {div_rem_reg, div_n_reg[NW-1]};
    assign q_ext     = SUMW'(div_n_reg);
    assign axis_sum  = SUMW'(cen_reg[ax_reg])
                     + (neg_reg[ax_reg] ? -$signed(q_ext) : $signed(q_ext));

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[slot_reg] <= cnt_reg[SW-1:0];
        end
        else if (state_reg == S_CLR)
        begin
            map_mem[clr_reg] <= '0;
        end
        if (in_acc)
        begin
            map_q <= map_mem[in_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            rev_mem[cnt_reg[SW-1:0]] <= slot_reg;
        end
        if (state_reg == S_MAP)
        begin
            rev_q <= rev_mem[map_q];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            cen_reg[0]    <= '0;
            cen_reg[1]    <= '0;
            cen_reg[2]    <= '0;
            rad_reg       <= sphc_pkg::RADIUS_RESET;
            out_valid_reg <= 1'b0;
            ax_reg        <= '0;
            it_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sphc_pkg::CFG_CENTER_X: cen_reg[0] <= cfg_data;
                    sphc_pkg::CFG_CENTER_Y: cen_reg[1] <= cfg_data;
                    sphc_pkg::CFG_CENTER_Z: cen_reg[2] <= cfg_data;
                    sphc_pkg::CFG_RADIUS:   rad_reg    <= cfg_data[RW-1:0];
                    default:                rad_reg    <= rad_reg;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == SW'(MAX_VERTICES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (start_mesh)
                        begin
                            cnt_reg <= '0;
                        end
                        slot_reg    <= in_slot;
                        pos_reg[0]  <= pos_x;
                        pos_reg[1]  <= pos_y;
                        pos_reg[2]  <= pos_z;
                        attr_reg[0] <= attr_a;
                        attr_reg[1] <= attr_b;
                        attr_reg[2] <= attr_c;
                        state_reg   <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    state_reg <= S_REV;
                end
                S_REV:
                begin
                    if (seen)
                    begin
                        ni_reg     <= map_q;
                        emit_reg   <= 1'b0;
                        carved_reg <= 1'b0;
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        ni_reg    <= cnt_reg[SW-1:0];
                        emit_reg  <= 1'b1;
                        if (cnt_reg < CNT_MAX)
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        ad_reg[i]  <= ad[i][RW-1:0];
                        neg_reg[i] <= d[i][DW-1];
                        res_reg[i] <= pos_reg[i];
                    end
                    carved_reg <= 1'b0;
                    acc_reg    <= '0;
                    ax_reg     <= '0;
                    state_reg  <= (&box) ? S_SQ : S_OUT;
                end
                S_SQ:
                begin
                    acc_reg <= acc_reg + sphc_pkg::D2_W'(sq_prod);
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= S_RCMP;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_RCMP:
                begin
                    if (acc_reg < sphc_pkg::D2_W'(rr))
                    begin
                        carved_reg <= 1'b1;
                        if (acc_reg == '0)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                res_reg[i] <= sat_coord(SUMW'(cen_reg[i]));
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            sq_n_reg   <= {acc_reg, 16'd0};
                            sq_rem_reg <= '0;
                            root_reg   <= '0;
                            it_reg     <= '0;
                            state_reg  <= S_SQRT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SQRT:
                begin
                    sq_n_reg <= {sq_n_reg[61:0], 2'b00};
                    if (sq_shift >= sq_trial)
                    begin
                        sq_rem_reg <= sq_shift - sq_trial;
                        root_reg   <= {root_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= sq_shift;
                        root_reg   <= {root_reg[QW-2:0], 1'b0};
                    end
                    it_reg <= it_reg + 6'd1;
                    if (it_reg == 6'(QW - 1))
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    div_n_reg   <= NW'({ax_prod, 8'd0}) + NW'(root_reg >> 1);
                    div_rem_reg <= '0;
                    it_reg      <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_shift >= {1'b0, root_reg})
                    begin
                        div_rem_reg <= QW'(div_shift - {1'b0, root_reg});
                        div_n_reg   <= {div_n_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= div_shift[QW-1:0];
                        div_n_reg   <= {div_n_reg[NW-2:0], 1'b0};
                    end
                    it_reg <= it_reg + 6'd1;
                    if (it_reg == 6'(NW - 1))
                    begin
                        state_reg <= S_AXIS;
                    end
                end
                S_AXIS:
                begin
                    res_reg[ax_reg] <= sat_coord(axis_sum);
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        new_index_reg    <= IW'({{IW{1'b0}}, ni_reg});
                        emits_vertex_reg <= emit_reg;
                        carved_out_reg   <= carved_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            out_pos_reg[i]  <= res_reg[i];
                            out_attr_reg[i] <= emit_reg ? attr_reg[i] : '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_index    = new_index_reg;
    assign emits_vertex = emits_vertex_reg;
    assign carved       = carved_out_reg;
    assign out_x        = out_pos_reg[0];
    assign out_y        = out_pos_reg[1];
    assign out_z        = out_pos_reg[2];
    assign out_attr_a   = out_attr_reg[0];
    assign out_attr_b   = out_attr_reg[1];
    assign out_attr_c   = out_attr_reg[2];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("fill count beyond map depth");

    a_carved_emits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && carved |-> emits_vertex)
        else $error("carved result without new vertex");

    a_repeat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !emits_vertex |-> out_x == '0 && out_attr_a == '0)
        else $error("repeated index carries vertex data");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        map_we && cnt_reg < CNT_MAX |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("new entry did not advance fill count");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sphere_carve_vertex_remap: drives index/vertex
// transactions with random gaps and output stalls, predicts remap and sphere
// projection per transaction, and compares every result with its prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NV = 4096;
    localparam int CW = 24;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [sphc_pkg::IDX_W-1:0] nidx;
        logic             emit;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [CW-1:0]    z;
        logic [CW-1:0]    a;
        logic [CW-1:0]    b;
        logic [CW-1:0]    c;
        logic             carv;
    } remap_res_t;

    class remap_scoreboard;
        logic [sphc_pkg::IDX_W-1:0] idx_map [NV];
        bit               seen [NV];
        int unsigned      fill;
        longint           cx, cy, cz;
        longint unsigned  rad;
        remap_res_t       pending[$];
        int               mismatches;
        int               results;
        int               carved_cnt;

        function void clear_map();
            for (int i = 0; i < NV; i++) seen[i] = 0;
            fill = 0;
        endfunction

        function void set_reg(sphc_pkg::cfg_idx_t ri, logic [sphc_pkg::REG_W-1:0] v);
            case (ri)
                sphc_pkg::CFG_CENTER_X: cx = longint'(signed'(v));
                sphc_pkg::CFG_CENTER_Y: cy = longint'(signed'(v));
                sphc_pkg::CFG_CENTER_Z: cz = longint'(signed'(v));
                sphc_pkg::CFG_RADIUS:   rad = longint'(v[sphc_pkg::RAD_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > n) bt >>= 2;
            while (bt != 0) begin
                if (n >= r + bt) begin
                    n -= r + bt;
                    r = (r >> 1) + bt;
                end else begin
                    r >>= 1;
                end
                bt >>= 2;
            end
            return r;
        endfunction

        function longint push_out(longint c, longint d, longint unsigned span);
            longint unsigned num, q;
            num = ((d < 0) ? -d : d) * rad * 256;
            q = (num + span / 2) / span;
            return sat(c + ((d < 0) ? -longint'(q) : longint'(q)));
        endfunction

        function void note_input(bit sm, logic [sphc_pkg::IDX_W-1:0] oi,
                                 logic [CW-1:0] px, py, pz, pa, pb, pc);
            remap_res_t e;
            longint dx, dy, dz, ox, oy, oz;
            longint unsigned ax, ay, az, d2, span;
            bit ins;
            e = '0;
            if (sm) clear_map();
            if (seen[oi]) begin
                e.nidx = idx_map[oi];
            end else begin
                dx = longint'(signed'(px)) - cx;
                dy = longint'(signed'(py)) - cy;
                dz = longint'(signed'(pz)) - cz;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                az = (dz < 0) ? -dz : dz;
                ox = signed'(px); oy = signed'(py); oz = signed'(pz);
                ins = 0;
                d2 = 0;
                if (ax < rad && ay < rad && az < rad) begin
                    d2 = ax * ax + ay * ay + az * az;
                    ins = d2 < rad * rad;
                end
                if (ins) begin
                    if (d2 == 0) begin
                        ox = cx; oy = cy; oz = cz;
                    end else begin
                        span = root(d2 << 16);
                        ox = push_out(cx, dx, span);
                        oy = push_out(cy, dy, span);
                        oz = push_out(cz, dz, span);
                    end
                end
                idx_map[oi] = fill[sphc_pkg::IDX_W-1:0];
                seen[oi] = 1;
                e.nidx = fill[sphc_pkg::IDX_W-1:0];
                if (fill < NV) fill++;
                e.emit = 1;
                e.x = ox[CW-1:0]; e.y = oy[CW-1:0]; e.z = oz[CW-1:0];
                e.a = pa; e.b = pb; e.c = pc;
                e.carv = ins;
            end
            pending = {pending, e};
        endfunction

        function void check_result(remap_res_t got);
            remap_res_t e;
            results++;
            if (got.carv) carved_cnt++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d\n  exp %p\n  got %p", results, e, got);
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_valid = 0;
    logic [1:0] cfg_index = '0;
    logic [sphc_pkg::REG_W-1:0] cfg_data = '0;
    logic cfg_ready;
    logic in_valid = 0, in_ready;
    logic start_mesh = 0;
    logic [sphc_pkg::IDX_W-1:0] old_index = '0;
    logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [CW-1:0] attr_a = '0, attr_b = '0, attr_c = '0;
    logic out_valid, out_ready = 0;
    logic [sphc_pkg::IDX_W-1:0] new_index;
    logic emits_vertex, carved;
    logic signed [CW-1:0] out_x, out_y, out_z, out_attr_a, out_attr_b, out_attr_c;

    remap_scoreboard sb = new();
    longint cycles = 0;
    int hold_off = 0;
    int sent = 0;
    bit sink_on = 0;

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    sphere_carve_vertex_remap dut (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side: random stall per transaction, plus a long hold-off window.
    int stall = 0;
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            sb.check_result({new_index, emits_vertex, out_x, out_y, out_z,
                             out_attr_a, out_attr_b, out_attr_c, carved});
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end else if (!sink_on) begin
            out_ready <= 0;
        end else if (stall > 0) begin
            stall = stall - 1;
            out_ready <= 0;
        end else begin
            out_ready <= 1;
        end
    end

    task automatic write_reg(sphc_pkg::cfg_idx_t ri, logic [sphc_pkg::REG_W-1:0] v);
        cfg_valid <= 1;
        cfg_index <= ri;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(ri, v);
    endtask

    task automatic set_sphere(logic [sphc_pkg::REG_W-1:0] x, y, z,
                              logic [sphc_pkg::RAD_W-1:0] r);
        write_reg(sphc_pkg::CFG_CENTER_X, x);
        write_reg(sphc_pkg::CFG_CENTER_Y, y);
        write_reg(sphc_pkg::CFG_CENTER_Z, z);
        write_reg(sphc_pkg::CFG_RADIUS, {1'b0, r});
        cfg_valid <= 0;
    endtask

    task automatic send(bit sm, logic [sphc_pkg::IDX_W-1:0] oi, logic [CW-1:0] px, py, pz,
                        logic [CW-1:0] pa, pb, pc, bit gaps);
        int g;
        g = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        start_mesh <= sm; old_index <= oi;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        attr_a <= pa; attr_b <= pb; attr_c <= pc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(sm, oi, px, py, pz, pa, pb, pc);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] near(longint c, longint r);
        longint v;
        v = c + $signed($urandom_range(0, 2 * r + 2)) - r - 1;
        return CW'(sb.sat(v));
    endfunction

    task automatic random_mesh(int n, bit gaps);
        int pool;
        logic [sphc_pkg::IDX_W-1:0] oi;
        logic [CW-1:0] px, py, pz;
        longint r;
        pool = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(2, 64);
        r = sb.rad;
        for (int i = 0; i < n; i++) begin
            oi = sphc_pkg::IDX_W'($urandom_range(0, pool - 1));
            if ($urandom_range(0, 4) == 0) begin
                px = CW'($urandom); py = CW'($urandom); pz = CW'($urandom);
            end else begin
                px = near(sb.cx, r); py = near(sb.cy, r); pz = near(sb.cz, r);
            end
            send(i == 0 || $urandom_range(0, 60) == 0, oi, px, py, pz,
                 CW'($urandom), CW'($urandom), CW'($urandom), gaps);
        end
    endtask

    initial begin
        logic [CW-1:0] mx, mn;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        sb.clear_map();
        sb.cx = 0; sb.cy = 0; sb.cz = 0; sb.rad = sphc_pkg::RADIUS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        sink_on <= 1;

        // directed: reset sphere, center, boundary, extremes, repeats
        send(1, 0, 0, 0, 0, mx, mn, 24'h5A5A5A, 0);
        send(0, 1, 8191, 0, 0, 1, 2, 3, 0);
        send(0, 2, 8192, 0, 0, 0, 0, 0, 0);
        send(0, 3, -4000, 3000, -2000, mx, mx, mx, 0);
        send(0, 0, 5, 5, 5, 0, 0, 0, 0);
        send(0, 12'hFFF, mx, mx, mx, mn, mn, mn, 0);
        send(0, 4, mn, mn, mn, 0, 0, 0, 0);
        send(0, 12'hFFF, 0, 0, 0, 0, 0, 0, 0);
        send(1, 12'hFFF, 1, -1, 1, 24'hA5A5A5, 0, 0, 0);
        send(0, 12'hAAA, 4095, 4096, 0, 0, 0, 0, 0);
        drain();
        set_sphere(mx, mn, mx, 23'h7FFFFF);
        send(1, 5, mx, mn, mx, 0, 0, 0, 0);
        send(0, 6, 0, 0, 0, 0, 0, 0, 0);
        send(0, 7, mx - 1, mn + 1, 0, 0, 0, 0, 0);
        send(0, 8, 24'h100000, 24'hF00000, 24'h400000, 0, 0, 0, 0);
        drain();
        set_sphere(100, -100, 50, 0);
        send(1, 1, 100, -100, 50, 0, 0, 0, 0);
        send(0, 2, 101, -100, 50, 0, 0, 0, 0);
        drain();
        set_sphere(24'h7FFF00, 0, 0, 23'h1000);
        send(1, 1, 24'h7FFF80, 0, 0, 0, 0, 0, 0);
        send(0, 2, 24'h7FFFF0, 16, -16, 0, 0, 0, 0);
        drain();

        // long receiver hold-off while sender keeps offering
        set_sphere(0, 0, 0, sphc_pkg::RADIUS_RESET);
        hold_off <= 400;
        random_mesh(30, 0);
        drain();

        // several sphere settings, random meshes
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: set_sphere(CW'($urandom), CW'($urandom), CW'($urandom),
                              sphc_pkg::RAD_W'($urandom_range(1, 1 << 14)));
                1: set_sphere(CW'($urandom), CW'($urandom), CW'($urandom),
                              sphc_pkg::RAD_W'($urandom));
                default: set_sphere(CW'($urandom_range(0, 4000)), 0, -3,
                                    sphc_pkg::RAD_W'($urandom_range(0, 40)));
            endcase
            random_mesh(140, ph % 4 != 3);
            drain();
        end

        // a run of fresh indices back to back, then one repeat
        set_sphere(0, 0, 0, 16);
        for (int i = 0; i < 40; i++)
            send(i == 0, i[sphc_pkg::IDX_W-1:0], CW'($urandom), CW'($urandom),
                 CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom), 0);
        send(0, 12'd7, 0, 0, 0, 0, 0, 0, 0);
        drain();

        $display("covered directed sphere corners, a long output hold-off and random meshes");
        $display("%0d transactions sent, %0d results checked, %0d carved vertices",
                 sent, sb.results, sb.carved_cnt);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
